### src/spcb_pkg.sv
// Shared types, codes and constants of the serial period command blinker.
package spcb_pkg;

    // Default depth of the line store in bytes
    localparam int LINE_BYTES_DEF = 32;

    // Characters of interest on the serial line
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Length of the command word
    localparam int WORD_LEN = 6;

    // Reset values of the configuration and blink registers
    localparam logic [15:0] MIN_PERIOD_RST   = 16'd10;
    localparam logic [15:0] MAX_PERIOD_RST   = 16'd60000;
    localparam logic [15:0] BLINK_PERIOD_RST = 16'd1000;
    localparam logic [15:0] ELAPSED_MAX      = 16'hFFFF;

    // The decimal value saturates here, which is always out of range
    localparam logic [19:0] VALUE_SAT = 20'd65536;

    // Configuration port widths and register indexes (index is paddr[2])
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_MIN_PERIOD = 1'b0;
    localparam logic REG_MAX_PERIOD = 1'b1;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;

    typedef enum logic {
        OP_BYTE,
        OP_TICK
    } op_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_ECHO,
        KIND_ERASE,
        KIND_EOL
    } echo_kind_t;

    typedef enum logic [2:0] {
        STAT_NONE,
        STAT_SET,
        STAT_MISSING,
        STAT_INVALID,
        STAT_RANGE,
        STAT_UNKNOWN,
        STAT_OVERFLOW
    } status_t;

    // Where the line parser stands
    typedef enum logic [1:0] {
        PH_WORD,
        PH_SPACE,
        PH_DIGIT
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_FINISH
    } ctrl_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic ready;
        logic step;
        logic scan_start;
        logic scan_read;
        logic scan_eval;
        logic finish;
    } spcb_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic res_full;
        logic res_take;
        logic eol_scan;
        logic scan_stop;
        logic scan_last;
    } spcb_stat_t;

    // Character of the command word at a given position
    function automatic logic [7:0] word_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h70; // p
            3'd1:    ch = 8'h65; // e
            3'd2:    ch = 8'h72; // r
            3'd3:    ch = 8'h69; // i
            3'd4:    ch = 8'h6F; // o
            default: ch = 8'h64; // d
        endcase
        return ch;
    endfunction

endpackage

### src/spcb_ctrl.sv
// Controller state machine: request acceptance and sequencing of the line scan.
module spcb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  spcb_pkg::spcb_stat_t  stat,
    output spcb_pkg::spcb_cmd_t   cmd
);
    import spcb_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                // A request is taken once the result stage has room for its answer.
                cmd.ready = !stat.res_full || stat.res_take;
                if (s_tvalid && cmd.ready)
                begin
                    if (stat.eol_scan)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_READ;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                cmd.scan_read = 1'b1;
                state_next    = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.scan_eval = 1'b1;
                if (stat.scan_stop || stat.scan_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### src/spcb_datapath.sv
// Datapath: line store, line parser, blink timer, configuration and result stages.
module spcb_datapath #(
    parameter int LINE_BYTES = spcb_pkg::LINE_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [spcb_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [spcb_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [1:0]                         m_tuser,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [spcb_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [spcb_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [spcb_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    input  spcb_pkg::spcb_cmd_t                cmd,
    output spcb_pkg::spcb_stat_t               stat
);
    import spcb_pkg::*;

    localparam int IDX_W = $clog2(LINE_BYTES);
    localparam int LEN_W = $clog2(LINE_BYTES + 1);

    // Line store, no reset: only entries below the line length are ever read
    logic [7:0] mem [LINE_BYTES];
    logic [7:0] rd_data_reg;
    logic       wr_en;

    // Control and blink state
    logic [LEN_W-1:0] len_reg,     len_next;
    logic             ovf_reg,     ovf_next;
    logic [15:0]      period_reg,  period_next;
    logic [15:0]      elapsed_reg, elapsed_next;
    logic             led_reg,     led_next;
    logic [15:0]      min_reg,     min_next;
    logic [15:0]      max_reg,     max_next;

    // Parser state
    logic [IDX_W-1:0] idx_reg,   idx_next;
    phase_t           phase_reg, phase_next;
    logic [16:0]      value_reg, value_next;
    status_t          perr_reg,  perr_next;

    // Result stage and output stage
    logic       res_valid_reg,  res_valid_next;
    echo_kind_t res_kind_reg,   res_kind_next;
    logic [7:0] res_byte_reg,   res_byte_next;
    status_t    res_status_reg, res_status_next;
    logic [15:0] res_period_reg, res_period_next;
    logic       res_led_reg,    res_led_next;
    logic       out_valid_reg,  out_valid_next;
    echo_kind_t out_kind_reg,   out_kind_next;
    logic [7:0] out_byte_reg,   out_byte_next;
    status_t    out_status_reg, out_status_next;
    logic [15:0] out_period_reg, out_period_next;
    logic       out_led_reg,    out_led_next;

    // Decoded request and helper values
    op_t         op_in;
    logic        is_eol;
    logic        is_bs;
    logic        short_line;
    logic        res_take;
    logic        scan_err;
    logic        cfg_wr;
    logic [15:0] elapsed_inc;
    logic [19:0] value_mul;
    logic [19:0] value_ext;

    assign op_in      = op_t'(s_tuser);
    assign is_eol     = (s_tdata == CHAR_LF) || (s_tdata == CHAR_CR);
    assign is_bs      = (s_tdata == CHAR_BS) || (s_tdata == CHAR_DEL);
    assign short_line = len_reg < LEN_W'(WORD_LEN);
    assign res_take   = res_valid_reg && (!out_valid_reg || m_tready);
    assign cfg_wr     = psel && penable && pwrite;

    assign elapsed_inc = (elapsed_reg != ELAPSED_MAX) ? elapsed_reg + 16'd1 : elapsed_reg;
    assign value_ext   = {3'b000, value_reg};
    assign value_mul   = (value_ext << 3) + (value_ext << 1) + {16'd0, rd_data_reg[3:0]};

    // Status towards the controller
    assign stat.res_full  = res_valid_reg;
    assign stat.res_take  = res_take;
    assign stat.eol_scan  = (op_in == OP_BYTE) && !ovf_reg && is_eol && !short_line;
    assign stat.scan_stop = scan_err;
    assign stat.scan_last = (LEN_W'(idx_reg) + LEN_W'(1)) == len_reg;

    // Configuration read port
    assign pready = 1'b1;
    assign prdata = {16'd0, (paddr[2] == REG_MAX_PERIOD) ? max_reg : min_reg};

    // Output stage towards the stream
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {4'd0, out_led_reg, out_period_reg, out_status_reg, out_byte_reg};

    // Next-state logic of all registers
    always_comb
    begin
        len_next        = len_reg;
        ovf_next        = ovf_reg;
        period_next     = period_reg;
        elapsed_next    = elapsed_reg;
        led_next        = led_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        idx_next        = idx_reg;
        phase_next      = phase_reg;
        value_next      = value_reg;
        perr_next       = perr_reg;
        res_valid_next  = res_valid_reg;
        res_kind_next   = res_kind_reg;
        res_byte_next   = res_byte_reg;
        res_status_next = res_status_reg;
        res_period_next = res_period_reg;
        res_led_next    = res_led_reg;
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_byte_next   = out_byte_reg;
        out_status_next = out_status_reg;
        out_period_next = out_period_reg;
        out_led_next    = out_led_reg;
        wr_en           = 1'b0;
        scan_err        = 1'b0;

        // Configuration writes
        if (cfg_wr)
        begin
            if (paddr[2] == REG_MAX_PERIOD)
            begin
                max_next = pwdata[15:0];
            end
            else
            begin
                min_next = pwdata[15:0];
            end
        end

        // Move the waiting result into the output stage
        if (res_take)
        begin
            res_valid_next  = 1'b0;
            out_valid_next  = 1'b1;
            out_kind_next   = res_kind_reg;
            out_byte_next   = res_byte_reg;
            out_status_next = res_status_reg;
            out_period_next = res_period_reg;
            out_led_next    = res_led_reg;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        // Handling of a tick or a byte that needs no line scan
        if (cmd.step)
        begin
            res_kind_next   = KIND_NONE;
            res_byte_next   = 8'd0;
            res_status_next = STAT_NONE;
            if (op_in == OP_TICK)
            begin
                if (elapsed_inc >= period_reg)
                begin
                    led_next     = !led_reg;
                    elapsed_next = 16'd0;
                end
                else
                begin
                    elapsed_next = elapsed_inc;
                end
            end
            else if (ovf_reg)
            begin
                // Discard until a line end, then report the overflow.
                if (is_eol)
                begin
                    ovf_next        = 1'b0;
                    len_next        = '0;
                    res_kind_next   = KIND_EOL;
                    res_status_next = STAT_OVERFLOW;
                end
            end
            else if (is_bs)
            begin
                if (len_reg != '0)
                begin
                    len_next      = len_reg - LEN_W'(1);
                    res_kind_next = KIND_ERASE;
                end
                else
                begin
                    res_kind_next = KIND_ECHO;
                    res_byte_next = s_tdata;
                end
            end
            else if (is_eol)
            begin
                // A line shorter than the command word is never a command.
                len_next        = '0;
                res_kind_next   = KIND_EOL;
                res_status_next = STAT_UNKNOWN;
            end
            else
            begin
                res_kind_next = KIND_ECHO;
                res_byte_next = s_tdata;
                if (len_reg < LEN_W'(LINE_BYTES))
                begin
                    wr_en    = 1'b1;
                    len_next = len_reg + LEN_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            res_valid_next  = 1'b1;
            res_period_next = period_reg;
            res_led_next    = led_next;
        end

        // Start of a line scan
        if (cmd.scan_start)
        begin
            idx_next   = '0;
            phase_next = PH_WORD;
            value_next = '0;
            perr_next  = STAT_NONE;
        end

        // One stored byte through the parser
        if (cmd.scan_eval)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (phase_reg == PH_WORD)
            begin
                if (idx_reg < IDX_W'(WORD_LEN))
                begin
                    if (rd_data_reg != word_char(idx_reg[2:0]))
                    begin
                        scan_err  = 1'b1;
                        perr_next = STAT_UNKNOWN;
                    end
                end
                else if (rd_data_reg != CHAR_SPACE)
                begin
                    scan_err  = 1'b1;
                    perr_next = STAT_UNKNOWN;
                end
                else
                begin
                    phase_next = PH_SPACE;
                end
            end
            else if ((phase_reg == PH_SPACE) && (rd_data_reg == CHAR_SPACE))
            begin
                phase_next = PH_SPACE;
            end
            else if ((rd_data_reg >= CHAR_ZERO) && (rd_data_reg <= CHAR_NINE))
            begin
                phase_next = PH_DIGIT;
                value_next = (value_mul > VALUE_SAT) ? VALUE_SAT[16:0] : value_mul[16:0];
            end
            else
            begin
                scan_err  = 1'b1;
                perr_next = STAT_INVALID;
            end
        end

        // Verdict on the scanned line
        if (cmd.finish)
        begin
            len_next        = '0;
            res_valid_next  = 1'b1;
            res_kind_next   = KIND_EOL;
            res_byte_next   = 8'd0;
            res_led_next    = led_reg;
            res_period_next = period_reg;
            if (perr_reg != STAT_NONE)
            begin
                res_status_next = perr_reg;
            end
            else if (phase_reg != PH_DIGIT)
            begin
                res_status_next = STAT_MISSING;
            end
            else if ((value_reg < {1'b0, min_reg}) || (value_reg > {1'b0, max_reg}))
            begin
                res_status_next = STAT_RANGE;
            end
            else
            begin
                res_status_next = STAT_SET;
                period_next     = value_reg[15:0];
                res_period_next = value_reg[15:0];
            end
        end
    end

    // Line store write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[len_reg[IDX_W-1:0]] <= s_tdata;
        end
        if (cmd.scan_read)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // Control, configuration and blink registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            period_reg    <= BLINK_PERIOD_RST;
            elapsed_reg   <= 16'd0;
            led_reg       <= 1'b0;
            min_reg       <= MIN_PERIOD_RST;
            max_reg       <= MAX_PERIOD_RST;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            period_reg    <= period_next;
            elapsed_reg   <= elapsed_next;
            led_reg       <= led_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Parser and result payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        phase_reg      <= phase_next;
        value_reg      <= value_next;
        perr_reg       <= perr_next;
        res_kind_reg   <= res_kind_next;
        res_byte_reg   <= res_byte_next;
        res_status_reg <= res_status_next;
        res_period_reg <= res_period_next;
        res_led_reg    <= res_led_next;
        out_kind_reg   <= out_kind_next;
        out_byte_reg   <= out_byte_next;
        out_status_reg <= out_status_next;
        out_period_reg <= out_period_next;
        out_led_reg    <= out_led_next;
    end

endmodule

### src/serial_period_command_blinker_unit.sv
// A tick or a byte request passes through the result stage and then the output stage to
// m_tdata. A line end that needs parsing walks the line store with a read and an evaluate
// state per stored byte (one memory read port); the verdict of the finish state then
// passes the result and output stages. Throughput: ticks and ordinary bytes at one
// request per cycle while the result stage has room; one line end at a time.
// Reset (rst_n, asynchronous, active low) empties the line, clears overflow, LED and
// elapsed time, sets the period to 1000 ms and the limits to 10 and 60000 ms.
module serial_period_command_blinker_unit #(
    parameter int LINE_BYTES = spcb_pkg::LINE_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input requests
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [spcb_pkg::S_TDATA_W-1:0]   s_tdata,  // [7:0] rx_byte
    input  logic                             s_tuser,  // [0] op
    // Results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] echo_byte, [10:8] status, [26:11] period_ms, [27] led, [31:28] zero
    output logic [spcb_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [1:0]                       m_tuser,  // [1:0] echo_kind
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [spcb_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [spcb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [spcb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import spcb_pkg::*;

    spcb_cmd_t  cmd;
    spcb_stat_t stat;

    assign s_tready = cmd.ready;

    // Sequencing
    spcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage, parsing and timing
    spcb_datapath #(
        .LINE_BYTES (LINE_BYTES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cmd      (cmd),
        .stat     (stat)
    );

`ifndef ASSERT_OFF
    // No new request is taken in the cycle after a line scan begins.
    a_scan_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_start |=> !s_tready)
        else $error("request accepted while a line scan was under way");

    // The verdict of a scan always finds the result stage empty.
    a_finish_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !stat.res_full)
        else $error("scan verdict would overwrite a waiting result");

    // Every parsed byte was read from the line store in the cycle before.
    a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_eval |-> $past(cmd.scan_read))
        else $error("parser evaluated a byte that was not read");
`endif

endmodule

### verif/blinker_check_pkg.sv
// Expected-result tracker for the serial period command blinker testbench.
`timescale 1ns / 100ps
package blinker_check_pkg;

    import spcb_pkg::*;

    // The command word, first character in the top byte
    localparam logic [8*WORD_LEN-1:0] CMD_WORD = "period";

    // Only the first ten failures are printed; later ones are only counted
    localparam int unsigned MAX_REPORTED = 10;

    // One result as the block should present it
    typedef struct {
        echo_kind_t  kind;
        logic [7:0]  echo;
        status_t     status;
        logic [15:0] period;
        logic        led;
    } blink_reply_t;

    class blinker_tracker;
        logic [7:0]   line_store [LINE_BYTES_DEF];
        int unsigned  line_len;
        bit           discarding;
        logic [15:0]  period_now;
        logic [15:0]  elapsed;
        bit           led_on;
        logic [15:0]  min_limit;
        logic [15:0]  max_limit;
        blink_reply_t awaited_replies [$];
        int unsigned  failures;

        function new();
            line_len   = 0;
            discarding = 1'b0;
            period_now = BLINK_PERIOD_RST;
            elapsed    = '0;
            led_on     = 1'b0;
            min_limit  = MIN_PERIOD_RST;
            max_limit  = MAX_PERIOD_RST;
            failures   = 0;
        endfunction

        function void set_limit(input logic idx, input logic [15:0] value);
            if (idx == REG_MIN_PERIOD)
                min_limit = value;
            else
                max_limit = value;
        endfunction

        function void flag_failure(input string msg);
            failures++;
            if (failures <= MAX_REPORTED)
                $display("%s", msg);
        endfunction

        // Verdict on a finished line; an accepted number becomes the blink period
        function status_t parse_line();
            int unsigned idx;
            int unsigned pos;
            int unsigned number;
            logic [7:0]  ch;
            if (line_len < WORD_LEN)
                return STAT_UNKNOWN;
            for (idx = 0; idx < WORD_LEN; idx++)
            begin
                if (line_store[idx] != CMD_WORD[8*(WORD_LEN-1-idx) +: 8])
                    return STAT_UNKNOWN;
            end
            if (line_len > WORD_LEN && line_store[WORD_LEN] != CHAR_SPACE)
                return STAT_UNKNOWN;
            pos = WORD_LEN;
            while (pos < line_len && line_store[pos] == CHAR_SPACE)
                pos++;
            if (pos >= line_len)
                return STAT_MISSING;
            number = 0;
            for (idx = pos; idx < line_len; idx++)
            begin
                ch = line_store[idx];
                if (ch < CHAR_ZERO || ch > CHAR_NINE)
                    return STAT_INVALID;
                number = number * 10 + (ch - CHAR_ZERO);
                // Saturate so that huge numbers stay out of range
                if (number > 65536)
                    number = 65536;
            end
            if (number < min_limit || number > max_limit)
                return STAT_RANGE;
            period_now = number[15:0];
            return STAT_SET;
        endfunction

        // Note an accepted request and queue the result it must give.
        // Returns 0 for a byte that is simply thrown away during overflow.
        function bit absorb_request(input op_t op, input logic [7:0] rx);
            blink_reply_t reply;
            bit           counted;
            reply.kind   = KIND_NONE;
            reply.echo   = '0;
            reply.status = STAT_NONE;
            counted      = 1'b1;
            if (op == OP_TICK)
            begin
                if (elapsed != ELAPSED_MAX)
                    elapsed++;
                if (elapsed >= period_now)
                begin
                    led_on  = !led_on;
                    elapsed = '0;
                end
            end
            else if (discarding)
            begin
                if (rx == CHAR_CR || rx == CHAR_LF)
                begin
                    discarding   = 1'b0;
                    line_len     = 0;
                    reply.kind   = KIND_EOL;
                    reply.status = STAT_OVERFLOW;
                end
                else
                    counted = 1'b0;
            end
            else if (rx == CHAR_BS || rx == CHAR_DEL)
            begin
                if (line_len != 0)
                begin
                    line_len--;
                    reply.kind = KIND_ERASE;
                end
                else
                begin
                    reply.kind = KIND_ECHO;
                    reply.echo = rx;
                end
            end
            else if (rx == CHAR_CR || rx == CHAR_LF)
            begin
                reply.kind   = KIND_EOL;
                reply.status = parse_line();
                line_len     = 0;
            end
            else
            begin
                reply.kind = KIND_ECHO;
                reply.echo = rx;
                if (line_len < LINE_BYTES_DEF)
                begin
                    line_store[line_len] = rx;
                    line_len++;
                end
                else
                    discarding = 1'b1;
            end
            reply.period = period_now;
            reply.led    = led_on;
            awaited_replies.push_back(reply);
            return counted;
        endfunction

        // Compare a result with the oldest one awaited.
        // data: [7:0] echo_byte, [10:8] status, [26:11] period_ms, [27] led
        function void check_reply(input logic [31:0] data, input logic [1:0] kind);
            blink_reply_t want;
            if (awaited_replies.size() == 0)
            begin
                flag_failure($sformatf("result with nothing awaited: kind %0d data %08h",
                                       kind, data));
                return;
            end
            want = awaited_replies.pop_front();
            if (kind !== want.kind || data[7:0] !== want.echo ||
                data[10:8] !== want.status || data[26:11] !== want.period ||
                data[27] !== want.led)
                flag_failure($sformatf({"mismatch: expected kind %0d byte %02h status %0d ",
                                        "period %0d led %0d, got kind %0d byte %02h ",
                                        "status %0d period %0d led %0d"},
                                       want.kind, want.echo, want.status, want.period,
                                       want.led, kind, data[7:0], data[10:8],
                                       data[26:11], data[27]));
        endfunction
    endclass

endpackage

### verif/tb_top.sv
// Top-level testbench of the serial period command blinker unit.
`timescale 1ns / 100ps
module tb_top;

    import spcb_pkg::*;
    import blinker_check_pkg::*;

    localparam int unsigned ITEM_TARGET   = 1900;
    localparam int unsigned NUM_PHASES    = 8;
    localparam int unsigned SETTLE_CYCLES = 2 * LINE_BYTES_DEF + 8;
    localparam int unsigned CYCLE_LIMIT   = 1000000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [7:0] rx_byte
    logic                  s_tuser;   // [0] op
    logic                  m_tvalid;
    logic                  m_tready;
    // [7:0] echo_byte, [10:8] status, [26:11] period_ms, [27] led
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [1:0]            m_tuser;   // [1:0] echo_kind
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    blinker_tracker tracker;
    bit             steady;
    int unsigned    items_sent;
    int unsigned    cycle_count;

    serial_period_command_blinker_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock generation
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Guard against a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Present one request after a random gap and wait until it is taken
    task automatic send_request(input op_t op, input logic [7:0] rx);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= rx;
        do
            @(posedge clk);
        while (!s_tready);
        if (tracker.absorb_request(op, rx))
            items_sent++;
    endtask

    // A received byte, now and then preceded by a tick
    task automatic send_byte(input logic [7:0] rx);
        if ($urandom_range(0, 19) == 0)
            send_request(OP_TICK, 8'($urandom_range(0, 255)));
        send_request(OP_BYTE, rx);
    endtask

    task automatic end_line();
        send_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
    endtask

    // Any byte that is neither an edit key nor a line end
    function automatic logic [7:0] ordinary_byte();
        logic [7:0] ch;
        do
            ch = 8'($urandom_range(0, 255));
        while (ch == CHAR_BS || ch == CHAR_DEL || ch == CHAR_CR || ch == CHAR_LF);
        return ch;
    endfunction

    // Send a line body; with_edit slips in a stray byte that is erased at once
    task automatic send_text(input string text, input bit with_edit);
        int spot;
        int idx;
        spot = with_edit ? int'($urandom_range(0, text.len() - 1)) : -1;
        for (idx = 0; idx < text.len(); idx++)
        begin
            if (idx == spot)
            begin
                send_byte(ordinary_byte());
                send_byte($urandom_range(0, 1) ? CHAR_BS : CHAR_DEL);
            end
            send_byte(text[idx]);
        end
    endtask

    // Let every awaited result arrive, then leave time for the block to go quiet
    task automatic settle_replies();
        s_tvalid <= 1'b0;
        while (tracker.awaited_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready
    task automatic write_limit(input logic idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        tracker.set_limit(idx, value);
        @(posedge clk);
    endtask

    // Result side: random stalls, check each accepted result
    initial
    begin
        int unsigned stall;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 14);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            tracker.check_reply(m_tdata, m_tuser);
        end
    end

    // Stimulus
    initial
    begin
        string       text;
        int unsigned value;
        int unsigned spot;
        int unsigned phase;
        int unsigned pick;
        int unsigned count;
        logic [7:0]  ch;
        logic [15:0] lo;
        logic [15:0] hi;

        tracker     = new();
        steady      = 1'b0;
        items_sent  = 0;
        cycle_count = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_BYTE;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        lo = MIN_PERIOD_RST;
        hi = MAX_PERIOD_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: edit keys on an empty line, erasing, extreme bytes,
        // an empty line, a tick, a bare word and a word without a space
        send_request(OP_BYTE, CHAR_BS);
        send_request(OP_BYTE, CHAR_DEL);
        send_request(OP_BYTE, 8'hFF);
        send_request(OP_BYTE, CHAR_DEL);
        send_request(OP_BYTE, 8'h00);
        send_request(OP_BYTE, CHAR_BS);
        send_request(OP_BYTE, CHAR_CR);
        send_request(OP_TICK, 8'hFF);
        send_text("period", 1'b0);
        send_request(OP_BYTE, CHAR_LF);
        send_text("period7", 1'b0);
        send_request(OP_BYTE, CHAR_CR);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            // New limits only while the block is idle
            if (phase != 0)
            begin
                settle_replies();
                case (phase)
                    1: begin lo = 16'd1;     hi = 16'd65535; end
                    2: begin lo = 16'd1;     hi = 16'd1;     end
                    3: begin lo = 16'd65535; hi = 16'd65535; end
                    4: begin lo = 16'd500;   hi = 16'd100;   end
                    5: begin lo = 16'd1;     hi = 16'd60;    end
                    6:
                    begin
                        lo = 16'($urandom_range(1, 65535));
                        hi = 16'($urandom_range(1, 65535));
                    end
                    default: begin lo = 16'd2; hi = 16'd200; end
                endcase
                write_limit(REG_MIN_PERIOD, lo);
                write_limit(REG_MAX_PERIOD, hi);
            end
            steady = ($urandom_range(0, 3) == 0);

            while (items_sent < (phase + 1) * ITEM_TARGET / NUM_PHASES)
            begin
                pick = $urandom_range(0, 99);
                text = "period";
                if (pick < 45)
                begin
                    // Well-formed command with a number that is small, near a limit or random
                    case ($urandom_range(0, 4))
                        0: value = $urandom_range(0, 40);
                        1: value = lo - 1 + $urandom_range(0, 2);
                        2: value = hi - 1 + $urandom_range(0, 2);
                        3: value = $urandom_range(0, 65535);
                        default: value = $urandom_range(65536, 99999999);
                    endcase
                    repeat ($urandom_range(1, 3)) text = {text, " "};
                    if ($urandom_range(0, 5) == 0)
                        text = {text, "000"};
                    text = {text, $sformatf("%0d", value)};
                    send_text(text, $urandom_range(0, 4) == 0);
                    end_line();
                end
                else if (pick < 53)
                begin
                    // Word with no number
                    repeat ($urandom_range(0, 3)) text = {text, " "};
                    send_text(text, $urandom_range(0, 4) == 0);
                    end_line();
                end
                else if (pick < 61)
                begin
                    // A non-digit among the digits
                    text = {"period ", $sformatf("%0d", $urandom_range(0, 99999))};
                    spot = $urandom_range(7, text.len() - 1);
                    do
                        ch = ordinary_byte();
                    while (ch >= CHAR_ZERO && ch <= CHAR_NINE);
                    text[spot] = ch;
                    send_text(text, 1'b0);
                    end_line();
                end
                else if (pick < 69)
                begin
                    // Misspelt word, word run into the next byte, or a short random line
                    if ($urandom_range(0, 2) == 0)
                    begin
                        count = $urandom_range(0, 5);
                        repeat (count) send_byte(ordinary_byte());
                    end
                    else
                    begin
                        text = {"period ", $sformatf("%0d", $urandom_range(0, 999))};
                        text[$urandom_range(0, WORD_LEN)] = ordinary_byte();
                        send_text(text, 1'b0);
                    end
                    end_line();
                end
                else if (pick < 77)
                begin
                    // Fill the store exactly or overrun it, at times with bytes thrown away after
                    count = $urandom_range(LINE_BYTES_DEF, LINE_BYTES_DEF + 8);
                    repeat (count) send_byte(ordinary_byte());
                    if (count > LINE_BYTES_DEF && $urandom_range(0, 1) == 1)
                    begin
                        repeat ($urandom_range(1, 4))
                        begin
                            do
                                ch = 8'($urandom_range(0, 255));
                            while (ch == CHAR_CR || ch == CHAR_LF);
                            send_byte(ch);
                        end
                    end
                    end_line();
                end
                else if (pick < 86)
                begin
                    // Raw noise, any byte value
                    repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
                end
                else
                begin
                    // Run of ticks
                    repeat ($urandom_range(1, 40))
                        send_request(OP_TICK, 8'($urandom_range(0, 255)));
                end
            end
        end

        // Wind down and give the verdict
        steady = 1'b0;
        settle_replies();
        if (tracker.awaited_replies.size() != 0)
            tracker.flag_failure("results still awaited at the end of the run");
        if (tracker.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
src/spcb_pkg.sv
src/spcb_ctrl.sv
src/spcb_datapath.sv
src/serial_period_command_blinker_unit.sv
verif/blinker_check_pkg.sv
verif/tb_top.sv
